// ===== rtl/gccs_pkg.sv =====
// Shared types and constants for the gold-code chip sequencer.
// Beat structs for the item and result channels, opcode letters, LFSR constants.
// No dependencies.
package gccs_pkg;

  localparam int CODE_W = 31;
  localparam logic [15:0] PERIOD_RESET = 16'd3124;
  localparam logic [15:0] PRNG_SEED = 16'hACE1;
  localparam logic [15:0] PRNG_TAPS = 16'hB400;
  localparam logic [15:0] F_OFFSET = 16'd640;
  localparam logic [7:0] FRAC_OFF = 8'd255;

  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_R = 8'h52;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_F = 3'd1;
  localparam logic [2:0] OP_C = 3'd2;
  localparam logic [2:0] OP_D = 3'd3;
  localparam logic [2:0] OP_P = 3'd4;

  localparam logic REG_CODE_WORD = 1'b0;
  localparam logic REG_NOMINAL = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic        dim_level;
    logic        sync_level;
    logic [15:0] cut_ticks;
    logic [15:0] chip_period;
    logic [7:0]  echo_byte;
  } result_t;

endpackage

// ===== rtl/gold_code_chip_sequencer_top.sv =====
// Gold-code chip sequencer top level: tick and command handling, word-start sequencer.
// Depends on gccs_pkg.
//
// Each beat on the item channel gives one result beat. A command beat or a tick inside
// a word is taken while the sequencer is idle and its result is registered at once. A
// tick that ends a word also redraws the flip mask: one shared multiplier and a small
// sequencer pass through a step and a mod state per wanted error (LFSR step with a
// reciprocal multiply, then the remainder and mask update) and then a level state for
// the first chip's level. The next item is taken once the sequencer is back in idle
// and the result register is free or being emptied.
// Registers: code_word at byte address 0, nominal_period at 4; writing nominal_period
// also restores the current period.
module gold_code_chip_sequencer_top
  import gccs_pkg::*;
#(
  parameter int CODE_LENGTH = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW = $clog2(CODE_LENGTH);
  localparam int CNTW = $clog2(CODE_LENGTH + 1);
  localparam int MSH = 16 + $clog2(CODE_LENGTH);
  localparam int RECIP = ((2 ** MSH) + CODE_LENGTH - 1) / CODE_LENGTH;
  localparam int PRODW = 16 + MSH;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_MOD = 2'd2;
  localparam logic [1:0] S_LEVEL = 2'd3;

  logic [1:0]             state;
  logic [CODE_W-1:0]      code_word;
  logic [15:0]            nominal_period;
  logic [15:0]            period_value;
  logic [PW-1:0]          chip_position;
  logic                   next_level;
  logic                   next_sync;
  logic [CNTW-1:0]        error_count;
  logic [CNTW-1:0]        blank_count;
  logic [CNTW-1:0]        errs_left;
  logic [7:0]             pulse_fraction;
  logic [CODE_LENGTH-1:0] flip_mask;
  logic [15:0]            prng_state;
  logic [2:0]             pending_op;
  logic [PRODW-1:0]       prod_q;

  logic              accept;
  logic              cfg_write;
  logic [15:0]       lfsr_next;
  logic [15:0]       mul_a;
  logic [MSH-1:0]    mul_b;
  logic [PRODW-1:0]  prod;
  logic [15:0]       quot;
  logic [15:0]       rem_full;
  logic [PW-1:0]     rem_pos;
  logic [PW-1:0]     pos_inc;
  logic              wrap;
  logic [PW-1:0]     lvl_pos;
  logic [CODE_W-1:0] lvl_code;
  logic [63:0]       code_ext;
  logic [5:0]        code_idx;
  logic              lvl;
  logic [15:0]       cut;
  logic [15:0]       f_period;
  logic [15:0]       cmd_period;
  logic [CNTW-1:0]   sat_val;
  logic [7:0]        b;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_NOMINAL) ? {16'd0, nominal_period}
                                            : {{(32 - CODE_W){1'b0}}, code_word};

  assign item_ready = (state == S_IDLE) && (!result_valid || result_ready);
  assign accept = item_valid && item_ready;
  assign b = item.rx_byte;

  // shared multiplier: cut ticks product in idle, reciprocal for lfsr mod CODE_LENGTH otherwise
  assign lfsr_next = (prng_state >> 1) ^ (prng_state[0] ? PRNG_TAPS : 16'd0);
  assign mul_a = (state == S_IDLE) ? period_value : lfsr_next;
  assign mul_b = (state == S_IDLE) ? MSH'(pulse_fraction) : MSH'(RECIP);
  assign prod = PRODW'(mul_a) * PRODW'(mul_b);
  assign cut = (pulse_fraction != 8'd0 && next_level) ? prod[23:8] : 16'd0;

  assign quot = 16'(prod_q >> MSH);
  assign rem_full = prng_state - 16'(quot * 16'(CODE_LENGTH));
  assign rem_pos = rem_full[PW-1:0];

  assign wrap = (chip_position == PW'(CODE_LENGTH - 1));
  assign pos_inc = chip_position + PW'(1);

  always_comb begin
    lvl_code = code_word;
    lvl_pos = pos_inc;
    if (cfg_write && paddr[2] == REG_CODE_WORD) begin
      lvl_code = pwdata[CODE_W-1:0];
      lvl_pos = chip_position;
    end else if (state == S_LEVEL) begin
      lvl_pos = '0;
    end
    code_ext = {{(64 - CODE_W){1'b0}}, lvl_code};
    code_idx = 6'(CODE_LENGTH - 1) - 6'(lvl_pos);
    lvl = code_ext[code_idx] ^ flip_mask[lvl_pos];
    if (CNTW'(lvl_pos) < blank_count) begin
      lvl = 1'b0;
    end
  end

  assign f_period = nominal_period + F_OFFSET - ({6'd0, b, 2'b00} + {8'd0, b});
  assign sat_val = ({1'b0, b} > 9'(CODE_LENGTH)) ? CNTW'(CODE_LENGTH) : CNTW'(b);

  // period reported on a command beat, after the command has taken effect
  always_comb begin
    cmd_period = period_value;
    if (pending_op == OP_F) begin
      cmd_period = f_period;
    end else if (pending_op == OP_NONE && b == CH_R) begin
      cmd_period = nominal_period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code_word <= '0;
      nominal_period <= PERIOD_RESET;
      period_value <= PERIOD_RESET;
      chip_position <= '0;
      next_level <= 1'b0;
      next_sync <= 1'b1;
      error_count <= '0;
      blank_count <= '0;
      errs_left <= '0;
      pulse_fraction <= '0;
      flip_mask <= '0;
      prng_state <= PRNG_SEED;
      pending_op <= OP_NONE;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (cfg_write) begin
        if (paddr[2] == REG_CODE_WORD) begin
          code_word <= pwdata[CODE_W-1:0];
          next_level <= lvl;
        end else begin
          nominal_period <= pwdata[15:0];
          period_value <= pwdata[15:0];
        end
      end

      case (state)
        S_IDLE: begin
          if (accept && !item.cmd) begin
            result <= '{dim_level: next_level, sync_level: next_sync, cut_ticks: cut,
                        chip_period: period_value, echo_byte: 8'd0};
            if (wrap) begin
              chip_position <= '0;
              flip_mask <= '0;
              errs_left <= error_count;
              state <= (error_count != '0) ? S_STEP : S_LEVEL;
            end else begin
              chip_position <= pos_inc;
              next_level <= lvl;
              next_sync <= 1'b0;
            end
          end else if (accept) begin
            result <= '{dim_level: next_level, sync_level: next_sync, cut_ticks: 16'd0,
                        chip_period: cmd_period, echo_byte: b};
            case (pending_op)
              OP_F: begin
                period_value <= f_period;
                pending_op <= OP_NONE;
              end
              OP_C: begin
                error_count <= sat_val;
                pending_op <= OP_NONE;
              end
              OP_D: begin
                blank_count <= sat_val;
                pending_op <= OP_NONE;
              end
              OP_P: begin
                pulse_fraction <= (b == FRAC_OFF) ? 8'd0 : b;
                pending_op <= OP_NONE;
              end
              OP_NONE: begin
                case (b)
                  CH_F: pending_op <= OP_F;
                  CH_C: pending_op <= OP_C;
                  CH_D: pending_op <= OP_D;
                  CH_P: pending_op <= OP_P;
                  CH_R: begin
                    period_value <= nominal_period;
                    error_count <= '0;
                    blank_count <= '0;
                    pulse_fraction <= '0;
                  end
                  default: ;
                endcase
              end
              default: pending_op <= OP_NONE;
            endcase
          end
        end
        S_STEP: begin
          prng_state <= lfsr_next;
          prod_q <= prod;
          state <= S_MOD;
        end
        S_MOD: begin
          flip_mask[rem_pos] <= 1'b1;
          errs_left <= errs_left - CNTW'(1);
          state <= (errs_left == CNTW'(1)) ? S_LEVEL : S_STEP;
        end
        S_LEVEL: begin
          next_level <= lvl;
          next_sync <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb_gold_code_chip_sequencer_top.sv =====
// Testbench for gold_code_chip_sequencer_top: directed and random tick and command beats
// over several code word and period settings, checked against a scoreboard class.
// Depends on gccs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_gold_code_chip_sequencer_top;
  import gccs_pkg::*;

  localparam int LIMIT = 400000;

  class chip_scoreboard;
    logic [30:0] code_word;
    logic [15:0] nominal;
    logic [4:0]  chip_pos;
    logic        next_level;
    logic        next_sync;
    logic [4:0]  err_cnt;
    logic [4:0]  blank_cnt;
    logic [7:0]  fraction;
    logic [30:0] flips;
    logic [15:0] lfsr;
    logic [2:0]  pending;
    logic [15:0] period;
    result_t     expected_q[$];
    int          errors;
    int          n_ticks;
    int          n_cmds;
    int          n_words;
    int          n_checked;

    function new();
      code_word = '0;
      nominal = PERIOD_RESET;
      chip_pos = '0;
      err_cnt = '0;
      blank_cnt = '0;
      fraction = '0;
      flips = '0;
      lfsr = PRNG_SEED;
      pending = OP_NONE;
      period = PERIOD_RESET;
      next_level = chip_level(0);
      next_sync = 1'b1;
      errors = 0;
      n_ticks = 0;
      n_cmds = 0;
      n_words = 0;
      n_checked = 0;
    endfunction

    function logic chip_level(int pos);
      logic b;
      b = code_word[CODE_W - 1 - pos];
      if (flips[pos]) b = ~b;
      if (pos < int'(blank_cnt)) b = 1'b0;
      return b;
    endfunction

    function logic [4:0] sat_count(logic [7:0] n);
      return (int'(n) > CODE_W) ? 5'(CODE_W) : n[4:0];
    endfunction

    function logic [31:0] reg_value(logic idx);
      return (idx == REG_CODE_WORD) ? {1'b0, code_word} : {16'd0, nominal};
    endfunction

    function void write_reg(logic idx, logic [31:0] v);
      if (idx == REG_CODE_WORD) begin
        code_word = v[30:0];
        next_level = chip_level(int'(chip_pos));
      end else begin
        nominal = v[15:0];
        period = nominal;
      end
    endfunction

    function void note_item(item_t it);
      result_t     r;
      logic [23:0] prod;
      logic        lsb;
      r = '0;
      r.dim_level = next_level;
      r.sync_level = next_sync;
      if (!it.cmd) begin
        n_ticks++;
        if (fraction != 8'd0 && next_level) begin
          prod = {8'd0, period} * {16'd0, fraction};
          r.cut_ticks = prod[23:8];
        end
        r.chip_period = period;
        if (int'(chip_pos) + 1 >= CODE_W) begin
          n_words++;
          chip_pos = '0;
          flips = '0;
          for (int i = 0; i < int'(err_cnt); i++) begin
            lsb = lfsr[0];
            lfsr = (lfsr >> 1) ^ (lsb ? PRNG_TAPS : 16'd0);
            flips[int'(lfsr) % CODE_W] = 1'b1;
          end
        end else begin
          chip_pos = chip_pos + 5'd1;
        end
        next_level = chip_level(int'(chip_pos));
        next_sync = (chip_pos == 5'd0);
      end else begin
        n_cmds++;
        if (pending != OP_NONE) begin
          case (pending)
            OP_F: period = 16'(int'(nominal) + int'(F_OFFSET) - 5 * int'(it.rx_byte));
            OP_C: err_cnt = sat_count(it.rx_byte);
            OP_D: blank_cnt = sat_count(it.rx_byte);
            OP_P: fraction = (it.rx_byte == FRAC_OFF) ? 8'd0 : it.rx_byte;
            default: ;
          endcase
          pending = OP_NONE;
        end else if (it.rx_byte == CH_F) begin
          pending = OP_F;
        end else if (it.rx_byte == CH_C) begin
          pending = OP_C;
        end else if (it.rx_byte == CH_D) begin
          pending = OP_D;
        end else if (it.rx_byte == CH_P) begin
          pending = OP_P;
        end else if (it.rx_byte == CH_R) begin
          period = nominal;
          err_cnt = '0;
          blank_cnt = '0;
          fraction = '0;
        end
        r.chip_period = period;
        r.echo_byte = it.rx_byte;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: %0h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.dim_level !== want.dim_level) begin
        $error("dim_level: expected %0h, got %0h", want.dim_level, got.dim_level);
        errors++;
      end
      if (got.sync_level !== want.sync_level) begin
        $error("sync_level: expected %0h, got %0h", want.sync_level, got.sync_level);
        errors++;
      end
      if (got.cut_ticks !== want.cut_ticks) begin
        $error("cut_ticks: expected %0h, got %0h", want.cut_ticks, got.cut_ticks);
        errors++;
      end
      if (got.chip_period !== want.chip_period) begin
        $error("chip_period: expected %0h, got %0h", want.chip_period, got.chip_period);
        errors++;
      end
      if (got.echo_byte !== want.echo_byte) begin
        $error("echo_byte: expected %0h, got %0h", want.echo_byte, got.echo_byte);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  item_t       item;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  chip_scoreboard sb = new();
  bit             calm;
  int             cycle_cnt;
  int             n_settings;

  gold_code_chip_sequencer_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_gold_code_chip_sequencer_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // receiver: random back-pressure, plus one long hold-off to fill the block
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sb.n_checked >= 60) begin
        held = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic send(logic c, logic [7:0] b);
    item_t it;
    it.cmd = c;
    it.rx_byte = b;
    while (!calm && $urandom_range(99) < 36) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic apb_write(logic idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check(logic idx);
    logic [31:0] want;
    want = sb.reg_value(idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prdata at %0h: expected %0h, got %0h", {idx, 2'b00}, want, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(logic [31:0] code, logic [31:0] nom);
    apb_write(REG_CODE_WORD, code);
    apb_write(REG_NOMINAL, nom);
    apb_check(REG_CODE_WORD);
    apb_check(REG_NOMINAL);
    n_settings++;
  endtask

  // idle the item side, wait for every result, then wait long enough for a word start to finish
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(3))
      0: return CH_F;
      1: return CH_C;
      2: return CH_D;
      default: return CH_P;
    endcase
  endfunction

  task automatic run_random(int n);
    int         k;
    int         r;
    logic [7:0] op;
    logic [7:0] v;
    k = 0;
    while (k < n) begin
      r = $urandom_range(99);
      if (r < 62) begin
        send(1'b0, 8'($urandom));
        k++;
      end else if (r < 84) begin
        op = pick_opcode();
        if ((op == CH_C || op == CH_D) && $urandom_range(3) != 0) v = 8'($urandom_range(35));
        else v = 8'($urandom_range(255));
        send(1'b1, op);
        send(1'b1, v);
        k += 2;
      end else if (r < 90) begin
        send(1'b1, CH_R);
        k++;
      end else if (r < 95) begin
        send(1'b1, 8'($urandom));
      end else begin
        // opcode whose value byte is itself an opcode letter
        send(1'b1, pick_opcode());
        send(1'b1, ($urandom_range(1) != 0) ? CH_R : pick_opcode());
        k += 2;
      end
    end
  endtask

  task automatic directed();
    send(1'b0, 8'h00);
    send(1'b0, 8'hFF);
    send(1'b1, CH_F);
    send(1'b1, 8'h00);
    send(1'b1, CH_F);
    send(1'b1, 8'hFF);
    send(1'b1, CH_C);
    send(1'b1, CH_D);
    send(1'b1, CH_D);
    send(1'b1, 8'd2);
    send(1'b1, CH_P);
    send(1'b1, 8'h80);
    repeat (3) send(1'b0, 8'($urandom));
    send(1'b1, CH_P);
    send(1'b1, FRAC_OFF);
    send(1'b1, 8'h5A);
    send(1'b1, 8'h00);
    send(1'b1, CH_R);
    send(1'b1, CH_C);
    send(1'b1, 8'd31);
    send(1'b1, CH_P);
    send(1'b1, 8'd1);
    send(1'b0, 8'h00);
  endtask

  initial begin : stimulus
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    cycle_cnt = 0;
    n_settings = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    apb_check(REG_CODE_WORD);
    apb_check(REG_NOMINAL);
    configure(32'h7FFF_FFFF, 32'h0000_FFFF);
    directed();
    run_random(150);

    drain();
    configure(32'h0000_0000, 32'h0000_0000);
    calm = 1'b1;
    run_random(120);
    calm = 1'b0;

    drain();
    configure($urandom, $urandom);
    run_random(130);

    drain();
    configure($urandom | 32'h8000_0000, {16'd0, PERIOD_RESET});
    run_random(100);

    drain();
    $display("covered %0d ticks, %0d command beats and %0d word starts over %0d settings",
             sb.n_ticks, sb.n_cmds, sb.n_words, n_settings);
    $display("%0d result beats checked, %0d mismatches", sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_gold_code_chip_sequencer_top: PASS");
    end else begin
      $display("tb_gold_code_chip_sequencer_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gccs_pkg.sv
rtl/gold_code_chip_sequencer_top.sv
tb/tb_gold_code_chip_sequencer_top.sv
